### rtl/assert_macros.svh
// Assertion helpers for the scan converter.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SP2C_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SP2C_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sp2c_pkg.sv
// Shared types and constants for the scan polar-to-cartesian converter.
// No dependencies; used by every module of the block but sp2c_fifo.
package sp2c_pkg;

    localparam int RANGE_W    = 20;
    localparam int POS_W      = 26;
    localparam int ANG_W      = 16;
    localparam int OFS_W      = 24;
    localparam int PTS_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SPAN_W     = 16;
    localparam int PROD_W     = PTS_W + SPAN_W;
    localparam int QUO_W      = 32;
    localparam int ZACC_W     = 34;
    localparam int Z_W        = 31;
    localparam int XY_W       = 32;
    localparam int ATAN_W     = 28;
    localparam int SC_W       = 23;

    // one full turn is 23040 * 2^16 angle units
    localparam logic [ZACC_W-1:0] MODV_U    = 34'd1509949440;
    localparam logic [35:0]       MODV3     = 36'd4529848320;
    localparam logic signed [31:0] MODV_S    = 32'sd1509949440;
    localparam logic signed [31:0] HALF_S    = 32'sd754974720;
    localparam logic signed [31:0] QUARTER_S = 32'sd377487360;
    localparam logic [29:0]       GAIN_Q30  = 30'd652032875;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGLE_MIN = 3'd0,
        CFG_ANGLE_MAX = 3'd1,
        CFG_MOUNT_YAW = 3'd2,
        CFG_MOUNT_X   = 3'd3,
        CFG_MOUNT_Y   = 3'd4,
        CFG_POINTS    = 3'd5
    } sp2c_cfg_idx_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] angle_min;
        logic signed [ANG_W-1:0] angle_max;
        logic signed [ANG_W-1:0] mount_yaw;
        logic signed [OFS_W-1:0] mount_x;
        logic signed [OFS_W-1:0] mount_y;
        logic [PTS_W-1:0]        points_per_scan;
    } sp2c_cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0]    range_value;
        logic signed [Z_W-1:0] angle;
        logic                  flip;
        logic                  span_error;
        logic                  last_of_scan;
    } sp2c_work_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic                    span_error;
        logic                    last_of_scan;
    } sp2c_result_t;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_MUL,
        FR_DIV,
        FR_ZINIT,
        FR_MOD,
        FR_FOLD,
        FR_PUSH
    } sp2c_front_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_ROT,
        BK_MULX,
        BK_MULY,
        BK_SCALE,
        BK_ADD,
        BK_PUSH
    } sp2c_back_state_t;

    // rounded arctangent of 2^-i in degrees * 2^22
    function automatic logic [ATAN_W-1:0] atan_val(input logic [4:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 28'd188743680;
            5'd1:    v = 28'd111421900;
            5'd2:    v = 28'd58872272;
            5'd3:    v = 28'd29884485;
            5'd4:    v = 28'd15000233;
            5'd5:    v = 28'd7507429;
            5'd6:    v = 28'd3754631;
            5'd7:    v = 28'd1877430;
            5'd8:    v = 28'd938729;
            5'd9:    v = 28'd469366;
            5'd10:   v = 28'd234683;
            5'd11:   v = 28'd117342;
            5'd12:   v = 28'd58671;
            5'd13:   v = 28'd29335;
            5'd14:   v = 28'd14668;
            5'd15:   v = 28'd7334;
            5'd16:   v = 28'd3667;
            5'd17:   v = 28'd1833;
            5'd18:   v = 28'd917;
            5'd19:   v = 28'd458;
            5'd20:   v = 28'd229;
            5'd21:   v = 28'd115;
            5'd22:   v = 28'd57;
            5'd23:   v = 28'd29;
            5'd24:   v = 28'd14;
            5'd25:   v = 28'd7;
            5'd26:   v = 28'd4;
            5'd27:   v = 28'd2;
            5'd28:   v = 28'd1;
            default: v = 28'd0;
        endcase
        return v;
    endfunction

endpackage

### rtl/sp2c_fifo.sv
// Small register-based FIFO used between the stages of the converter.
// No package dependency; width and depth come from parameters.
module sp2c_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [W-1:0] wdata,
    input  logic         pop,
    output logic         empty,
    output logic [W-1:0] rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### rtl/sp2c_front.sv
// Front end: takes range samples, tracks the point index and works out the
// folded rotation angle. Depends on sp2c_pkg.
module sp2c_front #(
    parameter int MAX_POINTS = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sp2c_pkg::sp2c_cfg_t             cfg,
    input  logic                            in_push,
    output logic                            in_full,
    input  logic [sp2c_pkg::RANGE_W-1:0]    range_value,
    input  logic                            first_point,
    output logic                            work_push,
    input  logic                            work_full,
    output sp2c_pkg::sp2c_work_t            work
);

    localparam int IDX_W    = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
    localparam int PW       = sp2c_pkg::PTS_W;
    localparam int ANG_W_P1 = sp2c_pkg::ANG_W + 1;

    sp2c_pkg::sp2c_front_state_t state_reg, state_next;

    logic [IDX_W-1:0]                 point_index_reg;
    logic [3:0]                       step_reg;
    logic [sp2c_pkg::RANGE_W-1:0]     range_reg;
    logic [PW-1:0]                    idx_reg;
    logic [PW-1:0]                    n_reg;
    logic [sp2c_pkg::SPAN_W-1:0]      span_reg;
    logic                             last_reg;
    logic                             err_reg;
    logic [PW-1:0]                    rem_reg;
    logic [sp2c_pkg::QUO_W-1:0]       quo_reg;
    logic [sp2c_pkg::ZACC_W-1:0]      zacc_reg;
    logic signed [sp2c_pkg::Z_W-1:0]  angle_reg;
    logic                             flip_reg;

    logic                             accept;
    logic [PW-1:0]                    n_eff;
    logic [PW-1:0]                    idx_cur;
    logic [PW-1:0]                    idx_use;
    logic [PW:0]                      idx_inc;
    logic [PW-1:0]                    idx_wrap;
    logic                             err_c;
    logic [ANG_W_P1-1:0]              span_c;
    logic [sp2c_pkg::PROD_W-1:0]      prod_c;
    logic [PW:0]                      r1;
    logic                             ge1;
    logic [PW-1:0]                    r1s;
    logic [PW:0]                      r2;
    logic                             ge2;
    logic [PW-1:0]                    r2s;
    logic [sp2c_pkg::ZACC_W-1:0]      mod_sub;
    logic signed [sp2c_pkg::ANG_W:0]  base_c;
    logic signed [35:0]               zsum_c;
    logic signed [31:0]               zs_c;
    logic signed [31:0]               zf_c;
    logic                             flip_c;

    // effective points per scan: zero means one, large values saturate
    always_comb
    begin
        if (cfg.points_per_scan == '0)
        begin
            n_eff = PW'(1);
        end
        else if (32'(cfg.points_per_scan) > MAX_POINTS)
        begin
            n_eff = PW'(MAX_POINTS);
        end
        else
        begin
            n_eff = cfg.points_per_scan;
        end
    end

    assign idx_cur  = PW'(point_index_reg);
    assign idx_use  = (first_point || idx_cur >= n_eff) ? '0 : idx_cur;
    assign idx_inc  = {1'b0, idx_use} + 1'b1;
    assign idx_wrap = (idx_inc >= {1'b0, n_eff}) ? '0 : idx_inc[PW-1:0];
    assign err_c    = $signed(cfg.angle_max) < $signed(cfg.angle_min);
    assign span_c   = {cfg.angle_max[sp2c_pkg::ANG_W-1], cfg.angle_max}
                    - {cfg.angle_min[sp2c_pkg::ANG_W-1], cfg.angle_min};
    assign accept   = in_push && (state_reg == sp2c_pkg::FR_IDLE);
    assign prod_c   = idx_reg * span_reg;

    // two quotient bits per cycle, restoring
    assign r1  = {rem_reg, quo_reg[sp2c_pkg::QUO_W-1]};
    assign ge1 = r1 >= {1'b0, n_reg};
    assign r1s = ge1 ? PW'(r1 - {1'b0, n_reg}) : PW'(r1);
    assign r2  = {r1s, quo_reg[sp2c_pkg::QUO_W-2]};
    assign ge2 = r2 >= {1'b0, n_reg};
    assign r2s = ge2 ? PW'(r2 - {1'b0, n_reg}) : PW'(r2);

    // offset by three turns keeps the angle sum non-negative
    assign base_c  = {cfg.angle_min[sp2c_pkg::ANG_W-1], cfg.angle_min}
                   + {cfg.mount_yaw[sp2c_pkg::ANG_W-1], cfg.mount_yaw};
    assign zsum_c  = $signed({{3{base_c[sp2c_pkg::ANG_W]}}, base_c, 16'b0})
                   + $signed({4'b0, quo_reg})
                   + $signed(sp2c_pkg::MODV3);
    assign mod_sub = sp2c_pkg::MODV_U << step_reg[1:0];

    // fold into [-90, 90] degrees, flipping the sign of both coordinates
    always_comb
    begin
        zs_c   = $signed({1'b0, zacc_reg[30:0]});
        if (zs_c >= sp2c_pkg::HALF_S)
        begin
            zs_c = zs_c - sp2c_pkg::MODV_S;
        end
        zf_c   = zs_c;
        flip_c = 1'b0;
        if (zs_c > sp2c_pkg::QUARTER_S)
        begin
            zf_c   = zs_c - sp2c_pkg::HALF_S;
            flip_c = 1'b1;
        end
        else if (zs_c < -sp2c_pkg::QUARTER_S)
        begin
            zf_c   = zs_c + sp2c_pkg::HALF_S;
            flip_c = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sp2c_pkg::FR_IDLE:
            begin
                if (in_push)
                begin
                    state_next = err_c ? sp2c_pkg::FR_PUSH : sp2c_pkg::FR_MUL;
                end
            end
            sp2c_pkg::FR_MUL:   state_next = sp2c_pkg::FR_DIV;
            sp2c_pkg::FR_DIV:
            begin
                if (step_reg == 4'd15)
                begin
                    state_next = sp2c_pkg::FR_ZINIT;
                end
            end
            sp2c_pkg::FR_ZINIT: state_next = sp2c_pkg::FR_MOD;
            sp2c_pkg::FR_MOD:
            begin
                if (step_reg[1:0] == 2'd0)
                begin
                    state_next = sp2c_pkg::FR_FOLD;
                end
            end
            sp2c_pkg::FR_FOLD:  state_next = sp2c_pkg::FR_PUSH;
            sp2c_pkg::FR_PUSH:
            begin
                if (!work_full)
                begin
                    state_next = sp2c_pkg::FR_IDLE;
                end
            end
            default:            state_next = sp2c_pkg::FR_IDLE;
        endcase
    end

    always_comb
    begin
        in_full   = (state_reg != sp2c_pkg::FR_IDLE);
        work_push = (state_reg == sp2c_pkg::FR_PUSH);
        work      = '{range_value:  range_reg,
                      angle:        angle_reg,
                      flip:         flip_reg,
                      span_error:   err_reg,
                      last_of_scan: last_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sp2c_pkg::FR_IDLE;
            point_index_reg <= '0;
            step_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                point_index_reg <= IDX_W'(idx_wrap);
            end
            case (state_reg)
                sp2c_pkg::FR_MUL:   step_reg <= '0;
                sp2c_pkg::FR_DIV:   step_reg <= step_reg + 1'b1;
                sp2c_pkg::FR_ZINIT: step_reg <= 4'd3;
                sp2c_pkg::FR_MOD:   step_reg <= step_reg - 1'b1;
                default:            step_reg <= step_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            sp2c_pkg::FR_IDLE:
            begin
                if (accept)
                begin
                    range_reg <= range_value;
                    idx_reg   <= idx_use;
                    n_reg     <= n_eff;
                    span_reg  <= span_c[sp2c_pkg::SPAN_W-1:0];
                    last_reg  <= (idx_use == n_eff - 1'b1);
                    err_reg   <= err_c;
                end
            end
            sp2c_pkg::FR_MUL:
            begin
                rem_reg <= prod_c[sp2c_pkg::PROD_W-1:16];
                quo_reg <= {prod_c[15:0], 16'b0};
            end
            sp2c_pkg::FR_DIV:
            begin
                rem_reg <= r2s;
                quo_reg <= {quo_reg[sp2c_pkg::QUO_W-3:0], ge1, ge2};
            end
            sp2c_pkg::FR_ZINIT:
            begin
                zacc_reg <= zsum_c[sp2c_pkg::ZACC_W-1:0];
            end
            sp2c_pkg::FR_MOD:
            begin
                if (zacc_reg >= mod_sub)
                begin
                    zacc_reg <= zacc_reg - mod_sub;
                end
            end
            sp2c_pkg::FR_FOLD:
            begin
                angle_reg <= zf_c[sp2c_pkg::Z_W-1:0];
                flip_reg  <= flip_c;
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/sp2c_back.sv
// Back end: iterative CORDIC rotation, gain scaling and mount offset.
// Depends on sp2c_pkg.
module sp2c_back #(
    parameter int CORDIC_STAGES = 18
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sp2c_pkg::sp2c_cfg_t    cfg,
    input  logic                   work_empty,
    output logic                   work_pop,
    input  sp2c_pkg::sp2c_work_t   work,
    output logic                   res_push,
    input  logic                   res_full,
    output sp2c_pkg::sp2c_result_t res
);

    localparam int STG_W = $clog2(CORDIC_STAGES);
    localparam int XW    = sp2c_pkg::XY_W;
    localparam int SW    = sp2c_pkg::SC_W;
    localparam int PRW   = 63;
    localparam logic signed [PRW-1:0] ROUND_HALF = 63'sh80_0000_0000;

    sp2c_pkg::sp2c_back_state_t state_reg, state_next;

    logic [STG_W-1:0]                    cnt_reg;
    logic signed [XW-1:0]                x_reg;
    logic signed [XW-1:0]                y_reg;
    logic signed [sp2c_pkg::Z_W-1:0]     z_reg;
    logic                                flip_reg;
    logic                                err_reg;
    logic                                last_reg;
    logic signed [PRW-1:0]               prod_reg;
    logic signed [SW-1:0]                rx_reg;
    logic signed [SW-1:0]                ry_reg;
    logic signed [sp2c_pkg::POS_W-1:0]   pos_x_reg;
    logic signed [sp2c_pkg::POS_W-1:0]   pos_y_reg;

    logic signed [XW-1:0]                dx_c;
    logic signed [XW-1:0]                dy_c;
    logic signed [sp2c_pkg::Z_W-1:0]     at_c;
    logic signed [XW-1:0]                mul_a;
    logic signed [PRW-1:0]               prod_c;
    logic signed [PRW-1:0]               rnd_c;
    logic signed [sp2c_pkg::POS_W-1:0]   rx_ext;
    logic signed [sp2c_pkg::POS_W-1:0]   ry_ext;
    logic signed [sp2c_pkg::POS_W-1:0]   sx_c;
    logic signed [sp2c_pkg::POS_W-1:0]   sy_c;

    assign dx_c   = y_reg >>> cnt_reg;
    assign dy_c   = x_reg >>> cnt_reg;
    assign at_c   = $signed({3'b0, sp2c_pkg::atan_val(5'(cnt_reg))});
    assign mul_a  = (state_reg == sp2c_pkg::BK_MULX) ? x_reg : y_reg;
    assign prod_c = mul_a * $signed({1'b0, sp2c_pkg::GAIN_Q30});
    assign rnd_c  = prod_reg + ROUND_HALF;
    assign rx_ext = {{(sp2c_pkg::POS_W - SW){rx_reg[SW-1]}}, rx_reg};
    assign ry_ext = {{(sp2c_pkg::POS_W - SW){ry_reg[SW-1]}}, ry_reg};
    assign sx_c   = flip_reg ? -rx_ext : rx_ext;
    assign sy_c   = flip_reg ? -ry_ext : ry_ext;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sp2c_pkg::BK_IDLE:
            begin
                if (!work_empty)
                begin
                    state_next = work.span_error ? sp2c_pkg::BK_PUSH : sp2c_pkg::BK_ROT;
                end
            end
            sp2c_pkg::BK_ROT:
            begin
                if (cnt_reg == STG_W'(CORDIC_STAGES - 1))
                begin
                    state_next = sp2c_pkg::BK_MULX;
                end
            end
            sp2c_pkg::BK_MULX:  state_next = sp2c_pkg::BK_MULY;
            sp2c_pkg::BK_MULY:  state_next = sp2c_pkg::BK_SCALE;
            sp2c_pkg::BK_SCALE: state_next = sp2c_pkg::BK_ADD;
            sp2c_pkg::BK_ADD:   state_next = sp2c_pkg::BK_PUSH;
            sp2c_pkg::BK_PUSH:
            begin
                if (!res_full)
                begin
                    state_next = sp2c_pkg::BK_IDLE;
                end
            end
            default:            state_next = sp2c_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        work_pop = (state_reg == sp2c_pkg::BK_IDLE) && !work_empty;
        res_push = (state_reg == sp2c_pkg::BK_PUSH);
        res      = '{pos_x:        pos_x_reg,
                     pos_y:        pos_y_reg,
                     span_error:   err_reg,
                     last_of_scan: last_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sp2c_pkg::BK_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == sp2c_pkg::BK_ROT)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            sp2c_pkg::BK_IDLE:
            begin
                if (!work_empty)
                begin
                    x_reg     <= $signed({2'b0, work.range_value, 10'b0});
                    y_reg     <= '0;
                    z_reg     <= work.angle;
                    flip_reg  <= work.flip;
                    err_reg   <= work.span_error;
                    last_reg  <= work.last_of_scan;
                    pos_x_reg <= '0;
                    pos_y_reg <= '0;
                end
            end
            sp2c_pkg::BK_ROT:
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - dx_c;
                    y_reg <= y_reg + dy_c;
                    z_reg <= z_reg - at_c;
                end
                else
                begin
                    x_reg <= x_reg + dx_c;
                    y_reg <= y_reg - dy_c;
                    z_reg <= z_reg + at_c;
                end
            end
            sp2c_pkg::BK_MULX:
            begin
                prod_reg <= prod_c;
            end
            sp2c_pkg::BK_MULY:
            begin
                prod_reg <= prod_c;
                rx_reg   <= rnd_c[PRW-1:40];
            end
            sp2c_pkg::BK_SCALE:
            begin
                ry_reg <= rnd_c[PRW-1:40];
            end
            sp2c_pkg::BK_ADD:
            begin
                pos_x_reg <= sx_c + {{2{cfg.mount_x[sp2c_pkg::OFS_W-1]}}, cfg.mount_x};
                pos_y_reg <= sy_c + {{2{cfg.mount_y[sp2c_pkg::OFS_W-1]}}, cfg.mount_y};
            end
            default:
            begin
            end
        endcase
    end

endmodule

### rtl/scan_polar_to_cartesian_core.sv
// Top level of the scan polar-to-cartesian converter: configuration
// registers, front end, work queue, CORDIC back end and result queue.
// Depends on sp2c_pkg, sp2c_front, sp2c_fifo, sp2c_back, assert_macros.svh.
//
// Usage:
//  - Input queue: a transaction on range_value/first_point completes when push
//    is high and full is low. full then stays high through the index
//    multiply, radix-4 divider, turn setup, 4-step turn reduction, fold and
//    work queue write, only through the write for a reversed span, and
//    longer while the work queue is full.
//  - Result queue: while empty is low the oldest result is on pos_x, pos_y,
//    span_error, last_of_scan; pop takes it.
//  - Back end: each sample goes through load, CORDIC_STAGES rotations (one per
//    cycle), two gain multiplies, rounding, offset add and result queue write.
//  - The front end takes a new sample only once the last one is in the work
//    queue, so it works on one sample while the back end works on another.
//  - Two-entry queues between the halves and at the output absorb pop stalls.
//  - Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
//    is always high. Write only while the block holds no work.
//  - Reset clears the index, queues and registers; points per scan is one.
`include "assert_macros.svh"

module scan_polar_to_cartesian_core #(
    parameter int MAX_POINTS    = 4096,
    parameter int CORDIC_STAGES = 18
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [sp2c_pkg::RANGE_W-1:0]        range_value,
    input  logic                                first_point,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [sp2c_pkg::POS_W-1:0]   pos_x,
    output logic signed [sp2c_pkg::POS_W-1:0]   pos_y,
    output logic                                span_error,
    output logic                                last_of_scan,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sp2c_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sp2c_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int WORK_W = $bits(sp2c_pkg::sp2c_work_t);
    localparam int RES_W  = $bits(sp2c_pkg::sp2c_result_t);

    sp2c_pkg::sp2c_cfg_t    cfg_reg;
    sp2c_pkg::sp2c_work_t   work_in;
    sp2c_pkg::sp2c_work_t   work_out;
    sp2c_pkg::sp2c_result_t res_in;
    sp2c_pkg::sp2c_result_t res_out;

    logic work_push;
    logic work_full;
    logic work_pop;
    logic work_empty;
    logic res_push;
    logic res_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_min       <= '0;
            cfg_reg.angle_max       <= '0;
            cfg_reg.mount_yaw       <= '0;
            cfg_reg.mount_x         <= '0;
            cfg_reg.mount_y         <= '0;
            cfg_reg.points_per_scan <= sp2c_pkg::PTS_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sp2c_pkg::CFG_ANGLE_MIN: cfg_reg.angle_min <= cfg_data[sp2c_pkg::ANG_W-1:0];
                sp2c_pkg::CFG_ANGLE_MAX: cfg_reg.angle_max <= cfg_data[sp2c_pkg::ANG_W-1:0];
                sp2c_pkg::CFG_MOUNT_YAW: cfg_reg.mount_yaw <= cfg_data[sp2c_pkg::ANG_W-1:0];
                sp2c_pkg::CFG_MOUNT_X:   cfg_reg.mount_x   <= cfg_data[sp2c_pkg::OFS_W-1:0];
                sp2c_pkg::CFG_MOUNT_Y:   cfg_reg.mount_y   <= cfg_data[sp2c_pkg::OFS_W-1:0];
                sp2c_pkg::CFG_POINTS:
                begin
                    cfg_reg.points_per_scan <= cfg_data[sp2c_pkg::PTS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    sp2c_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_push     (push),
        .in_full     (full),
        .range_value (range_value),
        .first_point (first_point),
        .work_push   (work_push),
        .work_full   (work_full),
        .work        (work_in)
    );

    sp2c_fifo #(
        .W     (WORK_W),
        .DEPTH (2)
    ) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (work_push),
        .full  (work_full),
        .wdata (work_in),
        .pop   (work_pop),
        .empty (work_empty),
        .rdata (work_out)
    );

    sp2c_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .work_empty (work_empty),
        .work_pop   (work_pop),
        .work       (work_out),
        .res_push   (res_push),
        .res_full   (res_full),
        .res        (res_in)
    );

    sp2c_fifo #(
        .W     (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res_in),
        .pop   (pop),
        .empty (empty),
        .rdata (res_out)
    );

    assign pos_x        = res_out.pos_x;
    assign pos_y        = res_out.pos_y;
    assign span_error   = res_out.span_error;
    assign last_of_scan = res_out.last_of_scan;

    `SP2C_ASSERT_SAME(a_err_zero_xy, !empty && span_error, pos_x == '0 && pos_y == '0, "span error result with nonzero coordinates")
    `SP2C_ASSERT_NEXT(a_busy_after_accept, push && !full, full, "front end not busy after transaction")
    `SP2C_ASSERT_SAME(a_no_pop_empty, work_pop, !work_empty, "back end popped empty work queue")
    `SP2C_ASSERT_NEXT(a_hold_result, res_push && res_full, res_push, "back end dropped a stalled result")

endmodule

### tb/scan_point_checker.sv
// Scoreboard for the scan polar-to-cartesian converter: tracks register writes,
// predicts each point from accepted samples, and compares popped results.
// Depends on sp2c_pkg for widths, register codes and the result struct.
module scan_point_checker
    import sp2c_pkg::*;
#(
    parameter int MAX_POINTS = 4096,
    parameter int STAGES     = 18
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic                       full,
    input  logic [RANGE_W-1:0]         range_value,
    input  logic                       first_point,
    input  logic                       empty,
    input  logic                       pop,
    input  logic signed [POS_W-1:0]    pos_x,
    input  logic signed [POS_W-1:0]    pos_y,
    input  logic                       span_error,
    input  logic                       last_of_scan,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    output int                         outstanding,
    output int                         mismatch_count
);

    localparam longint TURN       = 64'sd1509949440;   // 360 degrees * 2^22
    localparam longint GAIN       = 64'sd652032875;    // 0.60725293501 in Q30
    localparam longint ROUND_HALF = 64'sd549755813888; // 2^39

    // arctan(2^-i) in degrees * 2^22, rounded
    longint atan_steps [0:31] = '{
        188743680, 111421900, 58872272, 29884485, 15000233, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342, 58671,
        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0, 0, 0
    };

    logic signed [ANG_W-1:0] angle_lo;
    logic signed [ANG_W-1:0] angle_hi;
    logic signed [ANG_W-1:0] yaw;
    logic signed [OFS_W-1:0] offset_x;
    logic signed [OFS_W-1:0] offset_y;
    logic [PTS_W-1:0]        scan_points;
    logic [11:0]             scan_index;

    sp2c_result_t expected_points [$];

    // Converts one sample and advances the scan index.
    function automatic sp2c_result_t convert_point(input logic [RANGE_W-1:0] rng,
                                                   input logic restart);
        sp2c_result_t res;
        longint n, idx, span, off, z, x, y, dx, dy, px, py;
        logic err, last, flip;
        int i;
        n = scan_points;
        if (n == 0)
            n = 1;
        if (n > MAX_POINTS)
            n = MAX_POINTS;
        idx = scan_index;
        if (restart || idx >= n)
            idx = 0;
        last = (idx == n - 1);
        err = angle_hi < angle_lo;
        px = 0;
        py = 0;
        if (!err)
        begin
            span = longint'(angle_hi) - longint'(angle_lo);
            off = ((idx * span) << 16) / n;
            z = (longint'(angle_lo) + longint'(yaw)) * 65536 + off;
            z = ((z % TURN) + TURN) % TURN;
            if (z >= TURN / 2)
                z -= TURN;
            flip = 1'b0;
            // fold into [-90, 90]; the half turn is undone by negating x and y
            if (z > TURN / 4)
            begin
                z -= TURN / 2;
                flip = 1'b1;
            end
            else if (z < -TURN / 4)
            begin
                z += TURN / 2;
                flip = 1'b1;
            end
            x = longint'(rng) <<< 10;
            y = 0;
            for (i = 0; i < STAGES && i < 32; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x -= dx;
                    y += dy;
                    z -= atan_steps[i];
                end
                else
                begin
                    x += dx;
                    y -= dy;
                    z += atan_steps[i];
                end
            end
            x = (x * GAIN + ROUND_HALF) >>> 40;
            y = (y * GAIN + ROUND_HALF) >>> 40;
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            px = x + longint'(offset_x);
            py = y + longint'(offset_y);
        end
        idx += 1;
        if (idx >= n)
            idx = 0;
        scan_index = idx[11:0];
        res.pos_x = px[POS_W-1:0];
        res.pos_y = py[POS_W-1:0];
        res.span_error = err;
        res.last_of_scan = last;
        return res;
    endfunction

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sp2c_result_t want;
        if (!rst_n)
        begin
            angle_lo = '0;
            angle_hi = '0;
            yaw = '0;
            offset_x = '0;
            offset_y = '0;
            scan_points = PTS_W'(1);
            scan_index = '0;
            expected_points.delete();
            outstanding <= 0;
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ANGLE_MIN: angle_lo = cfg_data[ANG_W-1:0];
                    CFG_ANGLE_MAX: angle_hi = cfg_data[ANG_W-1:0];
                    CFG_MOUNT_YAW: yaw = cfg_data[ANG_W-1:0];
                    CFG_MOUNT_X:   offset_x = cfg_data[OFS_W-1:0];
                    CFG_MOUNT_Y:   offset_y = cfg_data[OFS_W-1:0];
                    CFG_POINTS:    scan_points = cfg_data[PTS_W-1:0];
                    default: ;
                endcase
            end
            if (push && !full)
                expected_points.push_back(convert_point(range_value, first_point));
            if (pop && !empty)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("result transaction with no sample pending: pos_x %0d pos_y %0d",
                           pos_x, pos_y);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    check_field("pos_x", want.pos_x, pos_x);
                    check_field("pos_y", want.pos_y, pos_y);
                    check_field("span_error", want.span_error, span_error);
                    check_field("last_of_scan", want.last_of_scan, last_of_scan);
                end
            end
            outstanding <= expected_points.size();
        end
    end

endmodule

### tb/tb_scan_polar_to_cartesian_core.sv
// Testbench top for scan_polar_to_cartesian_core: clock, reset, register
// setup, sample and result traffic with random stalls, and the verdict.
// Depends on sp2c_pkg, the converter RTL and scan_point_checker.
module tb_scan_polar_to_cartesian_core;
    import sp2c_pkg::*;

    localparam int MAX_PTS      = 4096;
    localparam int STAGES       = 18;
    localparam int RANDOM_ITEMS = 750;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 1000000;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic [RANGE_W-1:0]       range_value = '0;
    logic                     first_point = 1'b0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic                     span_error;
    logic                     last_of_scan;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    int outstanding;
    int mismatch_count;
    int cycle_count = 0;
    int random_sent = 0;
    bit push_eager = 1'b0;
    bit pop_eager = 1'b0;

    scan_polar_to_cartesian_core #(
        .MAX_POINTS    (MAX_PTS),
        .CORDIC_STAGES (STAGES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .range_value  (range_value),
        .first_point  (first_point),
        .empty        (empty),
        .pop          (pop),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .span_error   (span_error),
        .last_of_scan (last_of_scan),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    scan_point_checker #(
        .MAX_POINTS (MAX_PTS),
        .STAGES     (STAGES)
    ) u_point_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .range_value    (range_value),
        .first_point    (first_point),
        .empty          (empty),
        .pop            (pop),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .span_error     (span_error),
        .last_of_scan   (last_of_scan),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .outstanding    (outstanding),
        .mismatch_count (mismatch_count)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // push stays high from one sample to the next unless a gap is drawn
    task automatic send_sample(input logic [RANGE_W-1:0] rng, input logic restart);
        int gap;
        gap = push_eager ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        range_value <= rng;
        first_point <= restart;
        do @(posedge clk); while (full);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Unused upper data bits carry junk; the block must ignore them.
    task automatic configure(input shortint amin, input shortint amax, input shortint mount_yaw,
                             input int mx, input int my, input int pts, input bit spare);
        write_reg(CFG_ANGLE_MIN, {8'($urandom), 16'(amin)});
        write_reg(CFG_ANGLE_MAX, {8'($urandom), 16'(amax)});
        if (spare)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 24'($urandom));
        write_reg(CFG_MOUNT_YAW, {8'($urandom), 16'(mount_yaw)});
        write_reg(CFG_MOUNT_X, 24'(mx));
        write_reg(CFG_MOUNT_Y, 24'(my));
        write_reg(CFG_POINTS, {11'($urandom), 13'(pts)});
        cfg_valid <= 1'b0;
    endtask

    function automatic shortint draw_angle();
        case ($urandom_range(0, 15))
            0:       return -16'sd23040;
            1:       return 16'sd23040;
            2:       return shortint'($urandom);
            default: return shortint'(int'($urandom_range(0, 46080)) - 23040);
        endcase
    endfunction

    function automatic int draw_offset();
        case ($urandom_range(0, 9))
            0:       return 8388607;
            1:       return -8388608;
            2:       return int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
            default: return int'($urandom_range(0, 20000)) - 10000;
        endcase
    endfunction

    function automatic int draw_points();
        case ($urandom_range(0, 19))
            0:       return 0;
            1:       return MAX_PTS;
            2:       return $urandom_range(MAX_PTS + 1, 8191);
            3:       return $urandom_range(17, MAX_PTS);
            4:       return 1;
            default: return $urandom_range(2, 16);
        endcase
    endfunction

    function automatic logic [RANGE_W-1:0] draw_range();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return RANGE_W'($urandom_range(0, 1023));
            default: return RANGE_W'($urandom);
        endcase
    endfunction

    // result side: independent stalls, with stretches of back-to-back pops
    initial
    begin
        int gap;
        int run_left;
        run_left = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (run_left == 0)
            begin
                pop_eager = ($urandom_range(0, 3) == 0);
                run_left = $urandom_range(8, 40);
            end
            run_left--;
            gap = pop_eager ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin
        shortint amin, amax, tmp;
        int pts, eff, scans, len, k;
        logic restart;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: one point per scan, zero angles and offsets
        send_sample('0, 1'b0);
        send_sample('1, 1'b1);
        wait_drained();

        // full span with offset extremes; the index wraps after four points
        configure(-16'sd23040, 16'sd23040, 16'sd0, 8388607, -8388608, 4, 1'b0);
        send_sample('1, 1'b1);
        send_sample('1, 1'b0);
        send_sample('1, 1'b0);
        send_sample('1, 1'b0);
        send_sample(20'd12345, 1'b0);
        wait_drained();

        // reversed span: error flag, zero coordinates, index still moves
        configure(16'sd23040, -16'sd23040, 16'sd23040, 0, 0, 3, 1'b1);
        send_sample('1, 1'b1);
        send_sample(20'd1, 1'b0);
        send_sample(20'd2, 1'b0);
        wait_drained();

        // widest 16-bit angles; zero points behaves as one
        configure(shortint'(16'h8000), shortint'(16'h7FFF), -16'sd23040, -1, 1, 0, 1'b0);
        send_sample('1, 1'b0);
        send_sample(20'd500, 1'b1);
        wait_drained();

        // points above the maximum saturate
        configure(16'sd0, 16'sd23040, -16'sd23040, 0, 0, 8191, 1'b1);
        send_sample('1, 1'b1);
        send_sample(20'd777, 1'b0);
        send_sample('1, 1'b0);
        wait_drained();

        // shrink the scan under a running index: it must restart at zero
        configure(-16'sd11520, 16'sd11520, 16'sd5760, 1000, -1000, 100, 1'b0);
        send_sample(20'd4096, 1'b1);
        repeat (4) send_sample(draw_range(), 1'b0);
        wait_drained();
        configure(-16'sd11520, 16'sd11520, 16'sd5760, 1000, -1000, 3, 1'b0);
        send_sample(20'd65535, 1'b0);
        send_sample(20'd1024, 1'b0);
        wait_drained();

        while (random_sent < RANDOM_ITEMS)
        begin
            amin = draw_angle();
            amax = draw_angle();
            if ($urandom_range(0, 7) == 0 ? (amax > amin) : (amax < amin))
            begin
                tmp = amin;
                amin = amax;
                amax = tmp;
            end
            pts = draw_points();
            eff = (pts == 0) ? 1 : (pts > MAX_PTS) ? MAX_PTS : pts;
            configure(amin, amax, draw_angle(), draw_offset(), draw_offset(), pts,
                      $urandom_range(0, 5) == 0);
            push_eager = ($urandom_range(0, 3) == 0);
            scans = $urandom_range(1, 4);
            repeat (scans)
            begin
                len = (eff <= 24) ? eff : $urandom_range(8, 40);
                // a broken scan now and then
                if ($urandom_range(0, 5) == 0)
                    len = $urandom_range(1, len);
                for (k = 0; k < len; k++)
                begin
                    restart = (k == 0) && ($urandom_range(0, 4) != 0);
                    if ($urandom_range(0, 9) == 0)
                        restart = 1'($urandom_range(0, 1));
                    send_sample(draw_range(), restart);
                    random_sent++;
                end
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
